// ----- hdl/esc_pkg.sv -----
`timescale 1ns / 1ps

package esc_pkg;

  // Field widths.
  localparam int unsigned EpochW = 32;
  localparam int unsigned DaysW  = 17;
  localparam int unsigned RemW   = 6;
  localparam int unsigned StepW  = 1;

  // Constant divisors of the shared divider, at the width of the working value.
  localparam logic [EpochW-1:0] DivSecs  = 32'd60;
  localparam logic [EpochW-1:0] DivMins  = 32'd60;
  localparam logic [EpochW-1:0] DivHours = 32'd24;
  localparam logic [EpochW-1:0] DivWeek  = 32'd7;

  // Scaled reciprocals: the quotient is the product shifted right by the paired amount.
  // Sixty and twenty-four are exact over every 32-bit value; seven is exact
  // for any day count below 349525.
  localparam logic [EpochW-1:0] RecipSecs  = 32'h8888_8889;
  localparam logic [EpochW-1:0] RecipMins  = 32'h8888_8889;
  localparam logic [EpochW-1:0] RecipHours = 32'hAAAA_AAAB;
  localparam logic [EpochW-1:0] RecipWeek  = 32'd149797;
  localparam int unsigned ShiftSecs  = 37;
  localparam int unsigned ShiftMins  = 37;
  localparam int unsigned ShiftHours = 36;
  localparam int unsigned ShiftWeek  = 20;

  // Last step of one division pass: a multiply, then quotient and remainder.
  localparam logic [StepW-1:0] LastStep = 1'b1;

  // Year offset limit and the one century year in range that is not leap (2100).
  localparam logic [7:0] YearMax     = 8'd255;
  localparam logic [7:0] YearNoLeap  = 8'd130;
  localparam logic [1:0] LeapPhase   = 2'd2;
  localparam logic [3:0] MonthsInYr  = 4'd12;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_YEAR,
    S_MONTH,
    S_DONE
  } state_e;

  // Which constant the divider divides by in the current pass.
  typedef enum logic [1:0] {
    DIV_SEC,
    DIV_MIN,
    DIV_HOUR,
    DIV_WDAY
  } div_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic div_step;
    logic div_last;
    div_e div_sel;
    logic year_step;
    logic month_step;
    logic publish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic year_done;
    logic month_done;
  } stat_t;

  // Leap rule over the years 1970 to 2199 as an offset from 1970.
  function automatic logic is_leap(input logic [7:0] yr);
    is_leap = (yr[1:0] == LeapPhase) && (yr != YearNoLeap);
  endfunction

  function automatic logic [8:0] year_len(input logic [7:0] yr);
    year_len = is_leap(yr) ? 9'd366 : 9'd365;
  endfunction

  // Month length for a month index from 0, February set by the leap flag.
  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    unique case (mon)
      4'd1:                      month_len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   month_len = 5'd30;
      default:                   month_len = 5'd31;
    endcase
  endfunction

endpackage

// ----- hdl/esc_dp.sv -----
`timescale 1ns / 1ps

module esc_dp import esc_pkg::*; (
  input  logic              clk_i,
  input  logic [EpochW-1:0] epoch_seconds_i,
  input  cmd_t              cmd_i,
  output stat_t             stat_o,
  output logic [5:0]        second_o,
  output logic [5:0]        minute_o,
  output logic [4:0]        hour_o,
  output logic [2:0]        weekday_o,
  output logic [7:0]        year_offset_o,
  output logic [3:0]        month_o,
  output logic [4:0]        day_of_month_o
);

  logic [EpochW-1:0]   work_q, work_d;
  logic [2*EpochW-1:0] prod_q;
  logic [RemW-1:0]     rem_d;
  logic [5:0]          sec_q, min_q;
  logic [4:0]          hr_q;
  logic [2:0]          wday_q;
  logic [DaysW-1:0]    days_q;
  logic [7:0]          yr_q;
  logic [3:0]          mon_q;

  logic [EpochW-1:0]   divisor;
  logic [EpochW-1:0]   recip;
  logic [EpochW-1:0]   rem_full;
  logic [8:0]          ylen;
  logic [4:0]          mlen;

  // Divisor and its scaled reciprocal for the current pass.
  always_comb begin
    unique case (cmd_i.div_sel)
      DIV_SEC: begin
        divisor = DivSecs;
        recip   = RecipSecs;
      end
      DIV_MIN: begin
        divisor = DivMins;
        recip   = RecipMins;
      end
      DIV_HOUR: begin
        divisor = DivHours;
        recip   = RecipHours;
      end
      default: begin
        divisor = DivWeek;
        recip   = RecipWeek;
      end
    endcase
  end

  // Quotient from the high bits of the registered product; the remainder is what is left.
  always_comb begin
    unique case (cmd_i.div_sel)
      DIV_SEC:  work_d = EpochW'(prod_q >> ShiftSecs);
      DIV_MIN:  work_d = EpochW'(prod_q >> ShiftMins);
      DIV_HOUR: work_d = EpochW'(prod_q >> ShiftHours);
      default:  work_d = EpochW'(prod_q >> ShiftWeek);
    endcase
    rem_full = work_q - work_d * divisor;
    rem_d    = rem_full[RemW-1:0];
  end

  // Lengths of the current year and month.
  always_comb begin
    ylen = year_len(yr_q);
    mlen = month_len(mon_q, is_leap(yr_q));
  end

  assign stat_o.year_done  = (days_q < {{(DaysW-9){1'b0}}, ylen}) || (yr_q == YearMax);
  assign stat_o.month_done = (mon_q == MonthsInYr) || (days_q < {{(DaysW-5){1'b0}}, mlen});

  // Division passes: multiply in the first step, split quotient and remainder in the last.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      work_q <= epoch_seconds_i;
    end else if (cmd_i.div_step && cmd_i.div_last) begin
      work_q <= work_d;
    end
    if (cmd_i.div_step && !cmd_i.div_last) begin
      prod_q <= {{EpochW{1'b0}}, work_q} * {{EpochW{1'b0}}, recip};
    end
    if (cmd_i.div_step && cmd_i.div_last) begin
      unique case (cmd_i.div_sel)
        DIV_SEC:  sec_q  <= rem_d;
        DIV_MIN:  min_q  <= rem_d;
        DIV_HOUR: hr_q   <= rem_d[4:0];
        // The epoch day was a Thursday, so day zero of the count is weekday 5.
        default:  wday_q <= (rem_d[2:0] >= 3'd3) ? rem_d[2:0] - 3'd2 : rem_d[2:0] + 3'd5;
      endcase
    end
  end

  // Year and month walks over the day count.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      yr_q  <= '0;
      mon_q <= '0;
    end else if (cmd_i.div_step && cmd_i.div_last && (cmd_i.div_sel == DIV_HOUR)) begin
      days_q <= work_d[DaysW-1:0];
    end else if (cmd_i.year_step) begin
      days_q <= days_q - {{(DaysW-9){1'b0}}, ylen};
      yr_q   <= yr_q + 8'd1;
    end else if (cmd_i.month_step) begin
      days_q <= days_q - {{(DaysW-5){1'b0}}, mlen};
      mon_q  <= mon_q + 4'd1;
    end
  end

  // Output register: holds a finished word while the next one is worked on.
  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      second_o       <= sec_q;
      minute_o       <= min_q;
      hour_o         <= hr_q;
      weekday_o      <= wday_q;
      year_offset_o  <= yr_q;
      month_o        <= mon_q + 4'd1;
      day_of_month_o <= days_q[4:0] + 5'd1;
    end
  end

endmodule

// ----- hdl/esc_ctrl.sv -----
`timescale 1ns / 1ps

module esc_ctrl import esc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e           state_q, state_d;
  div_e             pass_q, pass_d;
  logic [StepW-1:0] step_q, step_d;
  logic             out_valid_q, out_valid_d;
  logic             last;

  assign last = (step_q == LastStep);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_DIV;
      S_DIV:   if (last && (pass_q == DIV_WDAY)) state_d = S_YEAR;
      S_YEAR:  if (stat_i.year_done) state_d = S_MONTH;
      S_MONTH: if (stat_i.month_done) state_d = S_DONE;
      S_DONE:  if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Commands and handshake outputs.
  always_comb begin
    cmd_o            = '0;
    cmd_o.div_sel    = pass_q;
    in_ready_o       = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cmd_o.div_last = last;
      end
      S_YEAR:  cmd_o.year_step  = !stat_i.year_done;
      S_MONTH: cmd_o.month_step = !stat_i.month_done;
      S_DONE:  cmd_o.publish    = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  // Step and pass counters, and the output valid flag.
  always_comb begin
    step_d = step_q;
    pass_d = pass_q;
    if (cmd_o.load) begin
      step_d = '0;
      pass_d = DIV_SEC;
    end else if (cmd_o.div_step) begin
      step_d = step_q + 1'b1;
      if (last) begin
        unique case (pass_q)
          DIV_SEC:  pass_d = DIV_MIN;
          DIV_MIN:  pass_d = DIV_HOUR;
          DIV_HOUR: pass_d = DIV_WDAY;
          default:  pass_d = DIV_SEC;
        endcase
      end
    end
    priority if (cmd_o.publish) out_valid_d = 1'b1;
    else if (out_ready_i)      out_valid_d = 1'b0;
    else                       out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pass_q      <= DIV_SEC;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pass_q      <= pass_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- hdl/epoch_seconds_to_calendar_unit.sv -----
`timescale 1ns / 1ps

// Channel  Handshake                 Payload
// input    in_valid_i / in_ready_o   epoch_seconds_i[31:0]
// output   out_valid_o / out_ready_i second_o, minute_o, hour_o, weekday_o,
//                                    year_offset_o, month_o, day_of_month_o
//
// One word passes through load, four passes of a shared reciprocal multiplier
// (by 60, 60, 24, 7), each a multiply and then a split into quotient and
// remainder, then a year walk that steps once per whole year, a month walk
// that steps once per month, and publication to the output register.
// Reset is asynchronous and active low and clears the controller only.
// The output register holds a finished word, so a new word is accepted while it waits.

module epoch_seconds_to_calendar_unit import esc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [EpochW-1:0] epoch_seconds_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [5:0]        second_o,
  output logic [5:0]        minute_o,
  output logic [4:0]        hour_o,
  output logic [2:0]        weekday_o,
  output logic [7:0]        year_offset_o,
  output logic [3:0]        month_o,
  output logic [4:0]        day_of_month_o
);

  cmd_t  cmd;
  stat_t stat;

  // Sequencer.
  esc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Divider, calendar walks and output register.
  esc_dp u_dp (
    .clk_i           (clk_i),
    .epoch_seconds_i (epoch_seconds_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .second_o        (second_o),
    .minute_o        (minute_o),
    .hour_o          (hour_o),
    .weekday_o       (weekday_o),
    .year_offset_o   (year_offset_o),
    .month_o         (month_o),
    .day_of_month_o  (day_of_month_o)
  );

endmodule

// ----- hdl/esc_checker.sv -----
`timescale 1ns / 1ps

module esc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [5:0] second_o,
  input logic [5:0] minute_o,
  input logic [4:0] hour_o,
  input logic [2:0] weekday_o,
  input logic [7:0] year_offset_o,
  input logic [3:0] month_o,
  input logic [4:0] day_of_month_o
);

  // A stalled word stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(second_o) && $stable(minute_o)
      && $stable(hour_o) && $stable(weekday_o) && $stable(year_offset_o)
      && $stable(month_o) && $stable(day_of_month_o))
    else $error("output word changed while stalled");

  // After a word is taken in, the unit is busy with it.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted again while busy");

  // A new result appears only at the end of work, when input was blocked.
  a_publish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared without a computation");

  // Every field of a valid word is in its calendar range.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (second_o < 6'd60) && (minute_o < 6'd60) && (hour_o < 5'd24)
      && (weekday_o != 3'd0) && (month_o != 4'd0) && (month_o < 4'd13)
      && (day_of_month_o != 5'd0) && (year_offset_o < 8'd137))
    else $error("output field out of range");

endmodule

bind epoch_seconds_to_calendar_unit esc_checker u_esc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .second_o       (second_o),
  .minute_o       (minute_o),
  .hour_o         (hour_o),
  .weekday_o      (weekday_o),
  .year_offset_o  (year_offset_o),
  .month_o        (month_o),
  .day_of_month_o (day_of_month_o)
);
